// ===== src/anti_replay_window_macros.svh =====
// assertion macros shared by the anti-replay window modules
// each macro expects clk and arst_n to be visible in the using module
`ifndef ANTI_REPLAY_WINDOW_MACROS_SVH
`define ANTI_REPLAY_WINDOW_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ARW_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ARW_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/arw_pkg.sv =====
// shared types and constants of the anti-replay window
// no dependencies
package arw_pkg;

	localparam int CTR_W = 32;

	typedef logic [CTR_W-1:0] ctr_t;
	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK   = 2'd0;
	localparam status_t STATUS_OLD  = 2'd1;
	localparam status_t STATUS_SEEN = 2'd2;

	// one input item
	typedef struct packed {
		logic record;
		ctr_t counter;
	} arw_item_t;

	// one result item
	typedef struct packed {
		logic    accepted;
		status_t status;
		ctr_t    base_now;
	} arw_result_t;

endpackage

// ===== src/arw_window.sv =====
// window state (base counter and seen bitmap) with the check and slide logic
// depends on arw_pkg and anti_replay_window_macros.svh
`include "anti_replay_window_macros.svh"

module arw_window
	import arw_pkg::*;
#(
	parameter int WINDOW_SIZE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  arw_item_t   item,
	output arw_result_t result
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam ctr_t WIN_C = ctr_t'(WINDOW_SIZE);
	localparam ctr_t TOP_C = ctr_t'(WINDOW_SIZE - 1);

	ctr_t                   base_q;
	logic [WINDOW_SIZE-1:0] bitmap_q;

	ctr_t                   diff;
	ctr_t                   amt;
	logic                   too_old;
	logic                   in_win;
	logic                   seen;
	logic                   ok;
	logic                   update;
	status_t                status;
	ctr_t                   base_next;
	logic [WINDOW_SIZE-1:0] bitmap_next;

	// check against the current window
	always_comb begin
		too_old = item.counter < base_q;
		diff    = item.counter - base_q;
		in_win  = diff < WIN_C;
		amt     = diff - TOP_C;
		seen    = !too_old && in_win && bitmap_q[diff[IDX_W-1:0]];
		ok      = !too_old && !seen;
		if (too_old) begin
			status = STATUS_OLD;
		end else if (seen) begin
			status = STATUS_SEEN;
		end else begin
			status = STATUS_OK;
		end
		update = fire && ok && item.record;
	end

	// slide and mark on an accepted record
	always_comb begin
		base_next   = base_q;
		bitmap_next = bitmap_q;
		if (update) begin
			if (in_win) begin
				bitmap_next[diff[IDX_W-1:0]] = 1'b1;
			end else begin
				base_next = item.counter - TOP_C;
				if (amt >= WIN_C) begin
					bitmap_next = '0;
				end else begin
					bitmap_next = bitmap_q >> amt[IDX_W-1:0];
				end
				bitmap_next[WINDOW_SIZE-1] = 1'b1;
			end
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bitmap_q <= '0;
		end else begin
			base_q   <= base_next;
			bitmap_q <= bitmap_next;
		end
	end

	// result reports the base after this item
	always_comb begin
		result.accepted = ok;
		result.status   = status;
		result.base_now = base_next;
	end

	`ARW_ASSERT_NEXT(a_base_monotonic, 1'b1, base_q >= $past(base_q), "window base moved back")
	`ARW_ASSERT_NEXT(a_check_keeps, fire && !item.record, $stable(base_q) && $stable(bitmap_q), "check changed state")
	`ARW_ASSERT_NEXT(a_reject_keeps, fire && !ok, $stable(base_q) && $stable(bitmap_q), "rejected item changed state")
	`ARW_ASSERT_NEXT(a_slide_marks_top, update && !in_win, bitmap_q[WINDOW_SIZE-1], "slide left top bit clear")

endmodule

// ===== src/anti_replay_window.sv =====
// top level of the anti-replay window: input register, window logic, result register
// depends on arw_pkg, arw_window and anti_replay_window_macros.svh
//
// Usage:
//   Input channel in_valid/in_ready carries command (0 check, 1 check and record)
//   and msg_counter. Output channel out_valid/out_ready carries accepted, status
//   (0 ok, 1 below base, 2 already seen) and base_now, the window base after the item.
//   One result per input item, in order.
//   Path: out_valid rises once the item has passed the input register and then the
//   result register, which holds the result until it transfers.
//   Throughput: one item per cycle while the receiver does not stall; the base and
//   bitmap are updated in the same cycle an item is checked, so the next item sees them.
//   Reset clears the base to zero and the whole bitmap, and empties both stages.
//   When the receiver stalls, the result stays in the result register and one
//   more item may wait in the input register; in_ready falls only when both are full.
`include "anti_replay_window_macros.svh"

module anti_replay_window
	import arw_pkg::*;
#(
	parameter int WINDOW_SIZE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [31:0] msg_counter,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic [1:0] status,
	output logic [31:0] base_now
);

	logic        valid_s1;
	arw_item_t   item_s1;
	logic        valid_s2;
	arw_result_t res_s2;
	arw_result_t result;
	logic        advance;
	logic        fire;

	// stage handshake
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.record  <= command;
			item_s1.counter <= msg_counter;
		end
	end

	// window check and update
	arw_window #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign accepted  = res_s2.accepted;
	assign status    = res_s2.status;
	assign base_now  = res_s2.base_now;

	`ARW_ASSERT_NOW(a_stall_full, !in_ready, valid_s1 && valid_s2, "input stalled with a free stage")
	`ARW_ASSERT_NEXT(a_fire_loads, fire, valid_s2, "processed item lost before result register")
	`ARW_ASSERT_NOW(a_status_code, valid_s2, res_s2.status <= STATUS_SEEN && (res_s2.accepted == (res_s2.status == STATUS_OK)), "result status inconsistent")

endmodule
